FILE: hdl/ssum_pkg.sv
// Shared types and constants for the sorted set union merge block.
`timescale 1ns / 1ps
package ssum_pkg;

  // Action codes carried by an input word
  localparam logic [1:0] ACT_APPEND_A = 2'd0;
  localparam logic [1:0] ACT_APPEND_B = 2'd1;
  localparam logic [1:0] ACT_RUN      = 2'd2;

  // Command queue geometry
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] in_value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               out_valid;
    logic               out_last;
    logic               overflow_seen;
  } result_t;

  typedef enum logic [1:0] {
    CMD_APPEND_A,
    CMD_APPEND_B,
    CMD_RUN
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic signed [31:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MERGE,
    ST_FLUSH
  } back_state_t;

endpackage

FILE: hdl/sorted_set_union_merge_core.sv
// Top level of the sorted set union merge block.
// Append words (action 0 to store A, 1 to store B) can arrive every cycle while the
// command queue has room; appends past DEPTH entries are dropped and raise the
// overflow flag carried on every word of the next run. A run word (action 2)
// emits the merge of both stores, ascending with each distinct value once when
// both were loaded in ascending order, with out_last on the final word (or one
// word with out_valid low if both stores are empty), then clears both stores and
// the flag. The merge loop reads one element per cycle, while the output is not
// stalled, from the single read port of each store. Action 3 is taken and
// ignored. Words queue in a two-entry buffer while a run is busy.
`timescale 1ns / 1ps
module sorted_set_union_merge_core #(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ssum_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output ssum_pkg::result_t result
);
  import ssum_pkg::*;

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  ssum_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  ssum_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  ssum_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: hdl/ssum_front.sv
// Front end: accepts input words and decodes them into queue commands.
`timescale 1ns / 1ps
module ssum_front (
  input  logic           item_valid,
  output logic           item_stall,
  input  ssum_pkg::item_t item,
  input  logic           q_full,
  output logic           q_push,
  output ssum_pkg::cmd_t q_cmd
);
  import ssum_pkg::*;

  // Hold off the source only when the queue has no room
  assign item_stall = q_full;

  // Decode action; the unused code is taken and dropped
  always_comb begin
    q_push      = 1'b0;
    q_cmd.op    = CMD_RUN;
    q_cmd.value = item.in_value;
    unique case (item.action)
      ACT_APPEND_A: begin
        q_cmd.op = CMD_APPEND_A;
        q_push   = item_valid && !q_full;
      end
      ACT_APPEND_B: begin
        q_cmd.op = CMD_APPEND_B;
        q_push   = item_valid && !q_full;
      end
      ACT_RUN: begin
        q_cmd.op = CMD_RUN;
        q_push   = item_valid && !q_full;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

FILE: hdl/ssum_queue.sv
// Two-entry command queue between front end and merge engine.
`timescale 1ns / 1ps
module ssum_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ssum_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output ssum_pkg::cmd_t head,
  output logic           empty
);
  import ssum_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full  = (fill == QCNT_W'(QDEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

FILE: hdl/ssum_back.sv
// Merge engine: element stores, counts, overflow flag and the merge sequencer.
`timescale 1ns / 1ps
module ssum_back #(
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  ssum_pkg::cmd_t   q_head,
  output logic             q_pop,
  output logic             result_valid,
  input  logic             result_stall,
  output ssum_pkg::result_t result
);
  import ssum_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [31:0] mem_a [DEPTH];
  logic signed [31:0] mem_b [DEPTH];
  logic signed [31:0] rd_a, rd_b;

  back_state_t        state, state_next;
  logic [CNT_W-1:0]   cnt_a, cnt_a_next, cnt_b, cnt_b_next;
  logic [CNT_W-1:0]   i_pos, i_pos_next, j_pos, j_pos_next;
  logic               ovf, ovf_next;
  logic               any_seen, any_seen_next;
  logic signed [31:0] last_val, last_val_next;
  logic               res_full, res_full_next;
  result_t            res;

  logic               wr_a, wr_b, emit;
  result_t            emit_word;
  logic [IDX_W-1:0]   addr_a, addr_b;
  logic               a_left, b_left, take_a, distinct, slot_free;
  logic signed [31:0] pick;

  assign result_valid = res_full;
  assign result       = res;
  assign slot_free    = !res_full || !result_stall;

  // Merge compare on the registered store heads
  assign a_left   = (i_pos < cnt_a);
  assign b_left   = (j_pos < cnt_b);
  assign take_a   = !b_left || (a_left && (rd_a <= rd_b));
  assign pick     = take_a ? rd_a : rd_b;
  assign distinct = !any_seen || (pick != last_val);

  // Next state and datapath control
  always_comb begin
    state_next    = state;
    cnt_a_next    = cnt_a;
    cnt_b_next    = cnt_b;
    i_pos_next    = i_pos;
    j_pos_next    = j_pos;
    ovf_next      = ovf;
    any_seen_next = any_seen;
    last_val_next = last_val;
    q_pop         = 1'b0;
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    emit          = 1'b0;
    emit_word     = '0;
    addr_a        = '0;
    addr_b        = '0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_head.op)
            CMD_APPEND_A: begin
              if (cnt_a == CNT_W'(DEPTH)) ovf_next = 1'b1;
              else begin
                wr_a       = 1'b1;
                cnt_a_next = cnt_a + 1'b1;
              end
            end
            CMD_APPEND_B: begin
              if (cnt_b == CNT_W'(DEPTH)) ovf_next = 1'b1;
              else begin
                wr_b       = 1'b1;
                cnt_b_next = cnt_b + 1'b1;
              end
            end
            CMD_RUN: begin
              i_pos_next    = '0;
              j_pos_next    = '0;
              any_seen_next = 1'b0;
              state_next    = ST_PRIME;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      // Fetch both heads after the last write has landed
      ST_PRIME: begin
        state_next = ST_MERGE;
      end
      // One element per step; a value is held until the next distinct one shows
      ST_MERGE: begin
        addr_a = i_pos[IDX_W-1:0];
        addr_b = j_pos[IDX_W-1:0];
        if (!(a_left || b_left)) begin
          state_next = ST_FLUSH;
        end else if (!(distinct && any_seen) || slot_free) begin
          if (take_a) i_pos_next = i_pos + 1'b1;
          else        j_pos_next = j_pos + 1'b1;
          addr_a = i_pos_next[IDX_W-1:0];
          addr_b = j_pos_next[IDX_W-1:0];
          if (distinct && any_seen) begin
            emit                    = 1'b1;
            emit_word.out_value     = last_val;
            emit_word.out_valid     = 1'b1;
            emit_word.out_last      = 1'b0;
            emit_word.overflow_seen = ovf;
          end
          if (distinct) begin
            last_val_next = pick;
            any_seen_next = 1'b1;
          end
        end
      end
      // Final word of the run, or the empty marker
      ST_FLUSH: begin
        if (slot_free) begin
          emit                    = 1'b1;
          emit_word.out_value     = any_seen ? last_val : '0;
          emit_word.out_valid     = any_seen;
          emit_word.out_last      = 1'b1;
          emit_word.overflow_seen = ovf;
          cnt_a_next              = '0;
          cnt_b_next              = '0;
          ovf_next                = 1'b0;
          state_next              = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    res_full_next = emit ? 1'b1 : (res_full && result_stall);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt_a    <= '0;
      cnt_b    <= '0;
      ovf      <= 1'b0;
      res_full <= 1'b0;
      any_seen <= 1'b0;
      i_pos    <= '0;
      j_pos    <= '0;
    end else begin
      state    <= state_next;
      cnt_a    <= cnt_a_next;
      cnt_b    <= cnt_b_next;
      ovf      <= ovf_next;
      res_full <= res_full_next;
      any_seen <= any_seen_next;
      i_pos    <= i_pos_next;
      j_pos    <= j_pos_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    last_val <= last_val_next;
    if (emit) res <= emit_word;
  end

  // Element stores with registered read
  always_ff @(posedge clk) begin
    if (wr_a) mem_a[cnt_a[IDX_W-1:0]] <= q_head.value;
    if (wr_b) mem_b[cnt_b[IDX_W-1:0]] <= q_head.value;
    rd_a <= mem_a[addr_a];
    rd_b <= mem_b[addr_b];
  end

endmodule

FILE: hdl/ssum_checker.sv
// Port-level checks for the sorted set union merge block, bound to the top level.
`timescale 1ns / 1ps
module ssum_port_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input ssum_pkg::result_t result
);
  import ssum_pkg::*;

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  // No result word right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word present after reset");

  // The empty-union marker always closes its run
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.out_valid |-> result.out_last)
    else $error("empty marker without last flag");

  // The empty-union marker carries a zero value
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.out_valid |-> result.out_value == '0)
    else $error("empty marker with nonzero value");

endmodule

bind sorted_set_union_merge_core ssum_port_checker u_ssum_port_checker (.*);

FILE: verif/ssum_checker.sv
// Checker for the sorted set union merge block: predicts every result word and compares.
`timescale 1ns / 1ps
module ssum_checker #(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  ssum_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  ssum_pkg::result_t result,
  output int                fail_count,
  output int                pending,
  output int                run_count,
  output int                result_count,
  output int                overflow_runs,
  output int                empty_runs
);
  import ssum_pkg::*;

  // Shadow copy of the two stores and their fill state
  logic signed [31:0] set_a [DEPTH];
  logic signed [31:0] set_b [DEPTH];
  int                 fill_a;
  int                 fill_b;
  logic               dropped;

  // Union words still owed by the block, oldest first
  result_t            union_q [$];
  result_t            want;

  int                 fails;
  int                 runs;
  int                 words_out;
  int                 ovf_runs;
  int                 empties;

  // Merge both stores into ascending distinct words, then empty them
  task automatic merge_union();
    int                 ia;
    int                 ib;
    int                 n;
    logic signed [31:0] pick;
    result_t            held;
    bit                 have_held;
    ia = 0;
    ib = 0;
    n = 0;
    have_held = 1'b0;
    held = '0;
    while ((ia < fill_a || ib < fill_b) && n < 2 * DEPTH) begin
      // A wins a tie
      if (ib >= fill_b || (ia < fill_a && set_a[ia] <= set_b[ib])) begin
        pick = set_a[ia];
        ia++;
      end else begin
        pick = set_b[ib];
        ib++;
      end
      if (!have_held || pick != held.out_value) begin
        if (have_held) union_q.push_back(held);
        held.out_value     = pick;
        held.out_valid     = 1'b1;
        held.out_last      = 1'b0;
        held.overflow_seen = dropped;
        have_held = 1'b1;
        n++;
      end
    end
    // Last word carries the end mark; an empty union gives one invalid word
    if (have_held) begin
      held.out_last = 1'b1;
    end else begin
      held = '0;
      held.out_last      = 1'b1;
      held.overflow_seen = dropped;
      empties++;
    end
    union_q.push_back(held);
    fill_a = 0;
    fill_b = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      union_q.delete();
      fill_a = 0;
      fill_b = 0;
      dropped = 1'b0;
      fails = 0;
      runs = 0;
      words_out = 0;
      ovf_runs = 0;
      empties = 0;
    end else begin
      // Predict from the accepted input word
      if (item_valid && !item_stall) begin
        case (item.action)
          ACT_APPEND_A: begin
            if (fill_a >= DEPTH) begin
              dropped = 1'b1;
            end else begin
              set_a[fill_a] = item.in_value;
              fill_a++;
            end
          end
          ACT_APPEND_B: begin
            if (fill_b >= DEPTH) begin
              dropped = 1'b1;
            end else begin
              set_b[fill_b] = item.in_value;
              fill_b++;
            end
          end
          ACT_RUN: begin
            runs++;
            if (dropped) ovf_runs++;
            merge_union();
          end
          default: ;
        endcase
      end

      // Compare the accepted result word with the oldest prediction
      if (result_valid && !result_stall) begin
        words_out++;
        if (union_q.size() == 0) begin
          $error("result word with nothing expected: out_value %0d", result.out_value);
          fails++;
        end else begin
          want = union_q.pop_front();
          if (result.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, result.out_value);
            fails++;
          end
          if (result.out_valid !== want.out_valid) begin
            $error("out_valid: expected %0b, got %0b", want.out_valid, result.out_valid);
            fails++;
          end
          if (result.out_last !== want.out_last) begin
            $error("out_last: expected %0b, got %0b", want.out_last, result.out_last);
            fails++;
          end
          if (result.overflow_seen !== want.overflow_seen) begin
            $error("overflow_seen: expected %0b, got %0b",
                   want.overflow_seen, result.overflow_seen);
            fails++;
          end
        end
      end
    end
    pending       <= union_q.size();
    fail_count    <= fails;
    run_count     <= runs;
    result_count  <= words_out;
    overflow_runs <= ovf_runs;
    empty_runs    <= empties;
  end

endmodule

FILE: verif/sorted_set_union_merge_core_test.sv
// Top of the sorted set union merge testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module sorted_set_union_merge_core_test;
  import ssum_pkg::*;

  localparam int         DEPTH       = 32;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         HOLD_CYCLES = 400;
  localparam int         SETTLE      = 20;

  // Shapes of a loaded sequence
  localparam int SEQ_DENSE     = 0;
  localparam int SEQ_SPARSE    = 1;
  localparam int SEQ_SCRAMBLED = 2;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int      fail_count;
  int      pending;
  int      run_count;
  int      result_count;
  int      overflow_runs;
  int      empty_runs;

  int      tx_idle     = 0;
  int      rx_idle     = 0;
  logic    hold_on     = 1'b0;
  int      words_sent  = 0;
  int      cycle_count = 0;

  sorted_set_union_merge_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  ssum_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending),
    .run_count    (run_count),
    .result_count (result_count),
    .overflow_runs(overflow_runs),
    .empty_runs   (empty_runs)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("no progress within %0d cycles, %0d words still expected", CYCLE_LIMIT, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= hold_on || ($urandom_range(99) < rx_idle);
    end
  end

  // Offer one word after a random gap and wait until it is taken
  task automatic send_word(input logic [1:0] act, input logic signed [31:0] val);
    item_t w;
    w.action   = act;
    w.in_value = val;
    while ($urandom_range(99) < tx_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (act != ACT_UNUSED) words_sent++;
  endtask

  // Hold the sender until every predicted word has come out
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [31:0] next_value(input logic signed [31:0] prev,
                                                    input int shape);
    case (shape)
      SEQ_DENSE:  return prev + $urandom_range(0, 3);
      SEQ_SPARSE: return prev + $urandom_range(0, 32'h0800_0000);
      default:    return $urandom;
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(0, 5);
    if (r < 95) return $urandom_range(6, 20);
    return $urandom_range(DEPTH - 1, DEPTH + 4);
  endfunction

  // Load both stores from start points up to 3 apart, interleaved, then run
  task automatic load_and_run(input int len_a, input int len_b, input int shape);
    int                 ia;
    int                 ib;
    logic signed [31:0] cur_a;
    logic signed [31:0] cur_b;
    logic signed [31:0] base;
    bit                 to_a;
    case ($urandom_range(3))
      0:       base = 32'sh8000_0000 + $urandom_range(0, 8);
      1:       base = 32'sh7fff_ffff - $urandom_range(0, 40);
      2:       base = $urandom_range(0, 20) - 10;
      default: base = $urandom;
    endcase
    ia = 0;
    ib = 0;
    cur_a = base;
    cur_b = base + $urandom_range(0, 3);
    while (ia < len_a || ib < len_b) begin
      // occasional unused action code as noise
      if ($urandom_range(99) < 4) send_word(ACT_UNUSED, $urandom);
      to_a = (ib >= len_b) || (ia < len_a && $urandom_range(1) == 1);
      if (to_a) begin
        send_word(ACT_APPEND_A, cur_a);
        cur_a = next_value(cur_a, shape);
        ia++;
      end else begin
        send_word(ACT_APPEND_B, cur_b);
        cur_b = next_value(cur_b, shape);
        ib++;
      end
    end
    send_word(ACT_RUN, $urandom);
  endtask

  task automatic random_set();
    int r;
    int shape;
    r = $urandom_range(99);
    shape = (r < 75) ? SEQ_DENSE : (r < 90) ? SEQ_SPARSE : SEQ_SCRAMBLED;
    load_and_run(pick_len(), pick_len(), shape);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase one: sparse sender, heavily stalled receiver
    tx_idle = 28;
    rx_idle <= 88;

    // Directed: empty union
    send_word(ACT_RUN, 32'sd0);
    // Extremes, a tie and duplicates across the stores
    send_word(ACT_APPEND_A, 32'sh8000_0000);
    send_word(ACT_APPEND_A, -32'sd1);
    send_word(ACT_APPEND_B, -32'sd1);
    send_word(ACT_APPEND_A, 32'sd0);
    send_word(ACT_APPEND_B, 32'sd5);
    send_word(ACT_APPEND_B, 32'sh7fff_ffff);
    send_word(ACT_RUN, 32'sh7fff_ffff);
    // Unused action code is ignored
    send_word(ACT_UNUSED, 32'sh5a5a_5a5a);
    send_word(ACT_APPEND_A, 32'sd9);
    send_word(ACT_UNUSED, -32'sd1);
    send_word(ACT_RUN, -32'sd1);
    // Repeats left in the tail copy
    send_word(ACT_APPEND_B, 32'sd7);
    send_word(ACT_APPEND_B, 32'sd7);
    send_word(ACT_APPEND_B, 32'sd7);
    send_word(ACT_RUN, 32'sd0);
    // Unsorted loads
    send_word(ACT_APPEND_A, 32'sd5);
    send_word(ACT_APPEND_A, 32'sd1);
    send_word(ACT_APPEND_B, 32'sd3);
    send_word(ACT_RUN, 32'sd0);
    wait_drained();

    // Receiver holds off while a full store overflows and runs queue up
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
      begin
        load_and_run(DEPTH + 2, 2, SEQ_DENSE);
        load_and_run(3, 1, SEQ_SPARSE);
        load_and_run(0, 2, SEQ_DENSE);
      end
    join
    wait_drained();

    while (words_sent < 55) random_set();
    wait_drained();

    // Phase two: sparse receiver stalls, sender mostly idle
    tx_idle = 88;
    rx_idle <= 28;
    while (words_sent < 110) random_set();
    wait_drained();

    // Phase three: no idling on either side
    tx_idle = 0;
    rx_idle <= 0;
    while (words_sent < 160) random_set();
    wait_drained();

    $display("Covered %0d input words over %0d runs, %0d result words checked.",
             words_sent, run_count, result_count);
    $display("Runs with dropped appends: %0d, empty unions: %0d.", overflow_runs, empty_runs);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sorted_set_union_merge_core.f
hdl/ssum_pkg.sv
hdl/ssum_front.sv
hdl/ssum_queue.sv
hdl/ssum_back.sv
hdl/sorted_set_union_merge_core.sv
hdl/ssum_checker.sv
verif/ssum_checker.sv
verif/sorted_set_union_merge_core_test.sv
